FILE: hw/rtl/program_stream_packet_framer_top_macros.svh
// ---------------------------------------------------------------------------
// Program stream packet framer - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_PACKET_FRAMER_TOP_MACROS_SVH
`define PROGRAM_STREAM_PACKET_FRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/psf_pkg.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - package
// Types, codes and constants shared by the framer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_SCAN  = 3'd0,
    PH_FIFTH = 3'd1,
    PH_SIXTH = 3'd2,
    PH_BODY  = 3'd3,
    PH_STUFF = 3'd4
  } phase_t;

  // kind of run queued between parser and emitter
  typedef enum logic [1:0] {
    RUN_ERR  = 2'd0,
    RUN_HDR  = 2'd1,
    RUN_BODY = 2'd2
  } run_kind_t;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_PACK  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  // configuration register indexes
  localparam int unsigned REG_MAX_PACKET = 0;

  localparam int unsigned LEN_W = 17;
  localparam logic [LEN_W-1:0] MAX_PACKET_RESET = 17'd65541;
  localparam logic [LEN_W-1:0] HDR_BYTES        = 17'd6;

  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [7:0]  PACK_ID      = 8'hBA;
  localparam logic [7:0]  MPEG2_MASK   = 8'hC0;
  localparam logic [7:0]  MPEG2_CODE   = 8'h40;
  localparam logic [7:0]  MPEG1_MASK   = 8'hF0;
  localparam logic [7:0]  MPEG1_CODE   = 8'h20;
  localparam logic [15:0] MPEG2_PACK_LEN = 16'd8;
  localparam logic [15:0] MPEG1_PACK_LEN = 16'd6;

  // header burst positions
  localparam logic [2:0] HDR_IDX_LAST = 3'd5;

  localparam int unsigned RUN_FIFO_DEPTH = 8;

  // one queued run: up to six results for one input byte
  typedef struct packed {
    run_kind_t  kind;
    logic [1:0] status;
    logic [7:0] b0;     // stream id, or body byte
    logic [7:0] b1;     // fifth header byte
    logic [7:0] b2;     // sixth header byte
    logic       last;   // packet ends on this run
  } run_t;

  // queue status seen by the emitter
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psf_in_if.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - input channel
// Valid/ready channel carrying one raw stream byte per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface psf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psf_out_if.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - result channel
// Valid/ready channel carrying one framed byte with its marks per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface psf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       last_of_run;
  logic [1:0] status;

  modport source (output valid, output out_byte, output first_of_packet,
                  output last_of_packet, output last_of_run, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input first_of_packet,
                  input last_of_packet, input last_of_run, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psf_cfg_regs.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - configuration registers
// APB-style register bank holding the packet size limit.
// ---------------------------------------------------------------------------
`default_nettype none

module psf_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic [psf_pkg::LEN_W-1:0] max_packet
);

  logic [psf_pkg::LEN_W-1:0] max_packet_r;
  logic                      sel_max;
  logic                      wr_en;

  // register index sits in paddr[2]
  assign sel_max = (paddr[2] == psf_pkg::REG_MAX_PACKET[0]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packet_r <= psf_pkg::MAX_PACKET_RESET;
    end else if (wr_en && sel_max) begin
      max_packet_r <= pwdata[psf_pkg::LEN_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = {{(32 - psf_pkg::LEN_W){1'b0}}, max_packet_r};
    end
  end

  assign max_packet = max_packet_r;

endmodule

`default_nettype wire

FILE: hw/rtl/psf_parser.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - parser
// Start-code search and packet length tracking; at most one run per input byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "program_stream_packet_framer_top_macros.svh"

module psf_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [7:0]                in_byte,
  input  wire logic [psf_pkg::LEN_W-1:0] max_packet,
  output logic                           push,
  output psf_pkg::run_t                  run
);

  psf_pkg::phase_t           phase_r, phase_nxt;
  logic [23:0]               window_r, window_nxt;
  logic [7:0]                stream_id_r, stream_id_nxt;
  logic [7:0]                fifth_r, fifth_nxt;
  logic [psf_pkg::LEN_W-1:0] left_r, left_nxt;
  logic                      pack_hdr_r, pack_hdr_nxt;
  logic [2:0]                stuff_r, stuff_nxt;

  // header decode on the sixth byte
  logic                      is_pack;
  logic                      mpeg2;
  logic                      mpeg1;
  logic [15:0]               size;
  logic [psf_pkg::LEN_W-1:0] total;
  logic                      too_large;
  logic [psf_pkg::LEN_W-1:0] left_dec;
  logic [2:0]                stuff_dec;
  logic [2:0]                stuff_new;

  assign is_pack = (stream_id_r == psf_pkg::PACK_ID);
  assign mpeg2   = ((fifth_r & psf_pkg::MPEG2_MASK) == psf_pkg::MPEG2_CODE);
  assign mpeg1   = ((fifth_r & psf_pkg::MPEG1_MASK) == psf_pkg::MPEG1_CODE);

  always_comb begin
    priority if (!is_pack) begin
      size = {fifth_r, in_byte};
    end else if (mpeg2) begin
      size = psf_pkg::MPEG2_PACK_LEN;
    end else begin
      size = psf_pkg::MPEG1_PACK_LEN;
    end
  end

  assign total     = {1'b0, size} + psf_pkg::HDR_BYTES;
  assign too_large = (total > max_packet);
  assign left_dec  = left_r - 1'b1;
  assign stuff_dec = stuff_r - 1'b1;
  assign stuff_new = pack_hdr_r ? in_byte[2:0] : 3'd0;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= psf_pkg::PH_SCAN;
      window_r    <= '0;
      stream_id_r <= '0;
      fifth_r     <= '0;
      left_r      <= '0;
      pack_hdr_r  <= 1'b0;
      stuff_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      window_r    <= window_nxt;
      stream_id_r <= stream_id_nxt;
      fifth_r     <= fifth_nxt;
      left_r      <= left_nxt;
      pack_hdr_r  <= pack_hdr_nxt;
      stuff_r     <= stuff_nxt;
    end
  end

  // next state and run to queue
  always_comb begin
    phase_nxt     = phase_r;
    window_nxt    = window_r;
    stream_id_nxt = stream_id_r;
    fifth_nxt     = fifth_r;
    left_nxt      = left_r;
    pack_hdr_nxt  = pack_hdr_r;
    stuff_nxt     = stuff_r;
    push          = 1'b0;
    run.kind      = psf_pkg::RUN_BODY;
    run.status    = psf_pkg::STATUS_OK;
    run.b0        = in_byte;
    run.b1        = fifth_r;
    run.b2        = in_byte;
    run.last      = 1'b0;

    if (accept) begin
      unique case (phase_r)
        psf_pkg::PH_SCAN: begin
          if (window_r == psf_pkg::START_PREFIX) begin
            stream_id_nxt = in_byte;
            phase_nxt     = psf_pkg::PH_FIFTH;
            window_nxt    = '0;
          end else begin
            window_nxt = {window_r[15:0], in_byte};
          end
        end
        psf_pkg::PH_FIFTH: begin
          fifth_nxt = in_byte;
          phase_nxt = psf_pkg::PH_SIXTH;
        end
        psf_pkg::PH_SIXTH: begin
          push = 1'b1;
          if ((is_pack && !mpeg2 && !mpeg1) || too_large) begin
            // error result, back to scanning
            run.kind     = psf_pkg::RUN_ERR;
            run.status   = (is_pack && !mpeg2 && !mpeg1) ?
                           psf_pkg::STATUS_BAD_PACK : psf_pkg::STATUS_TOO_LARGE;
            run.last     = 1'b1;
            phase_nxt    = psf_pkg::PH_SCAN;
            window_nxt   = '0;
            left_nxt     = '0;
            pack_hdr_nxt = 1'b0;
            stuff_nxt    = '0;
          end else begin
            run.kind = psf_pkg::RUN_HDR;
            run.b0   = stream_id_r;
            run.last = (size == 16'd0);
            if (size == 16'd0) begin
              // empty packet ends on its header
              phase_nxt    = psf_pkg::PH_SCAN;
              window_nxt   = '0;
              left_nxt     = '0;
              pack_hdr_nxt = 1'b0;
              stuff_nxt    = '0;
            end else begin
              left_nxt     = {1'b0, size};
              pack_hdr_nxt = is_pack && mpeg2;
              phase_nxt    = psf_pkg::PH_BODY;
            end
          end
        end
        psf_pkg::PH_BODY: begin
          push     = 1'b1;
          run.last = (left_dec == '0);
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt    = psf_pkg::PH_SCAN;
            window_nxt   = '0;
            left_nxt     = '0;
            pack_hdr_nxt = 1'b0;
            stuff_nxt    = '0;
            if (stuff_new != 3'd0) begin
              stuff_nxt = stuff_new;
              phase_nxt = psf_pkg::PH_STUFF;
            end
          end
        end
        psf_pkg::PH_STUFF: begin
          stuff_nxt = stuff_dec;
          if (stuff_dec == 3'd0) begin
            phase_nxt    = psf_pkg::PH_SCAN;
            window_nxt   = '0;
            left_nxt     = '0;
            pack_hdr_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt    = psf_pkg::PH_SCAN;
          window_nxt   = '0;
          left_nxt     = '0;
          pack_hdr_nxt = 1'b0;
          stuff_nxt    = '0;
        end
      endcase
    end
  end

  // stuffing phase always has bytes to drop; body always has bytes left
  `PSF_ASSERT_IMP(a_stuff_nonzero, clk, rst_n, phase_r == psf_pkg::PH_STUFF, stuff_r != 3'd0, "stuffing phase with zero count")
  `PSF_ASSERT_IMP(a_body_nonzero, clk, rst_n, phase_r == psf_pkg::PH_BODY, left_r != '0, "body phase with no bytes left")

endmodule

`default_nettype wire

FILE: hw/rtl/psf_run_fifo.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - run queue
// Small register queue of runs between the parser and the emitter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "program_stream_packet_framer_top_macros.svh"

module psf_run_fifo #(
  parameter int unsigned DEPTH = psf_pkg::RUN_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire psf_pkg::run_t din,
  input  wire logic          pop,
  output psf_pkg::run_t      dout,
  output psf_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  psf_pkg::run_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign dout       = entries[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `PSF_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !stat.full, "run pushed into a full queue")
  `PSF_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !stat.empty, "run popped from an empty queue")

endmodule

`default_nettype wire

FILE: hw/rtl/psf_emitter.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - emitter
// Expands queued runs into single results and holds the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "program_stream_packet_framer_top_macros.svh"

module psf_emitter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psf_pkg::run_t       head,
  input  wire psf_pkg::fifo_stat_t stat,
  output logic                     pop,
  psf_out_if.source                out_if
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       first_r, last_r, run_end_r;
  logic [1:0] status_r;

  logic       load, take, final_item;
  logic [7:0] item_byte;
  logic       item_first, item_last, item_run_end;
  logic [1:0] item_status;

  assign final_item = (head.kind != psf_pkg::RUN_HDR) || (idx_r == psf_pkg::HDR_IDX_LAST);
  assign load       = !valid_r || out_if.ready;
  assign take       = load && !stat.empty;
  assign pop        = take && final_item;

  // select the current item of the head run
  always_comb begin
    item_byte    = 8'h00;
    item_first   = 1'b0;
    item_last    = 1'b0;
    item_run_end = 1'b1;
    item_status  = psf_pkg::STATUS_OK;
    unique case (head.kind)
      psf_pkg::RUN_ERR: begin
        item_status = head.status;
      end
      psf_pkg::RUN_BODY: begin
        item_byte = head.b0;
        item_last = head.last;
      end
      psf_pkg::RUN_HDR: begin
        item_run_end = 1'b0;
        unique case (idx_r)
          3'd0: item_first = 1'b1;
          3'd1: item_byte  = 8'h00;
          3'd2: item_byte  = 8'h01;
          3'd3: item_byte  = head.b0;
          3'd4: item_byte  = head.b1;
          default: begin
            item_byte    = head.b2;
            item_last    = head.last;
            item_run_end = 1'b1;
          end
        endcase
      end
      default: begin
        item_status = psf_pkg::STATUS_OK;
      end
    endcase
  end

  // item index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= !stat.empty;
      end
      if (take) begin
        idx_r <= final_item ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r    <= item_byte;
      first_r   <= item_first;
      last_r    <= item_last;
      run_end_r <= item_run_end;
      status_r  <= item_status;
    end
  end

  assign out_if.valid           = valid_r;
  assign out_if.out_byte        = byte_r;
  assign out_if.first_of_packet = first_r;
  assign out_if.last_of_packet  = last_r;
  assign out_if.last_of_run     = run_end_r;
  assign out_if.status          = status_r;

  // a burst in progress always has its header run at the queue head
  `PSF_ASSERT_IMP(a_burst_head, clk, rst_n, idx_r != 3'd0, !stat.empty && head.kind == psf_pkg::RUN_HDR, "header burst lost its run")

endmodule

`default_nettype wire

FILE: hw/rtl/program_stream_packet_framer_top.sv
// ---------------------------------------------------------------------------
// Program stream packet framer - top level
// Frames MPEG program stream packets from a byte stream.
// ---------------------------------------------------------------------------
//  channel   | direction | transfer
//  in_if     | sink      | one raw stream byte (in_byte)
//  out_if    | source    | one framed byte with first/last marks and status
//  psel ...  | APB slave | max_packet_bytes at byte address 0
//
// One input byte is taken per cycle while the queue has room; the parser
// handles it in the cycle it is taken and queues at most one run. A header
// run leaves as six results, all others as one, via an 8-entry run queue.
// in_if.ready falls only while that queue is full; out_if stalls hold the
// output register. Synchronous reset clears all control state and sets the
// size limit to 65541; there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module program_stream_packet_framer_top #(
  parameter int unsigned FIFO_DEPTH = psf_pkg::RUN_FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  psf_in_if.sink           in_if,
  psf_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [psf_pkg::LEN_W-1:0] max_packet;
  logic                      accept;
  logic                      push, pop;
  psf_pkg::run_t             run_in, run_head;
  psf_pkg::fifo_stat_t       stat;

  assign in_if.ready = !stat.full;
  assign accept      = in_if.valid && !stat.full;

  psf_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_packet (max_packet)
  );

  psf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_if.in_byte),
    .max_packet (max_packet),
    .push       (push),
    .run        (run_in)
  );

  psf_run_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (run_in),
    .pop   (pop),
    .dout  (run_head),
    .stat  (stat)
  );

  psf_emitter u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (run_head),
    .stat   (stat),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

FILE: verif/tb_program_stream_packet_framer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Program stream packet framer - testbench
// Feeds raw program stream bytes through the input channel and checks every
// framed byte against an in-bench framing predictor: ordinary and empty
// packets, MPEG-1 and MPEG-2 pack headers with stuffing, bad pack types and
// the packet size limit over its extremes, then random packet streams with
// noise and broken start codes under random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_program_stream_packet_framer_top;

  localparam logic [2:0] LIMIT_ADDR     = 3'(4 * psf_pkg::REG_MAX_PACKET);
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 4000;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run;
    logic [1:0] status;
  } frame_res_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  psf_in_if  in_ch ();
  psf_out_if out_ch ();

  program_stream_packet_framer_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // framing predictor state
  psf_pkg::phase_t scan_phase;
  logic [23:0]     prefix_window;
  logic [7:0]      held_id;
  logic [7:0]      held_len_hi;
  logic [16:0]     body_left;
  logic            pack_mpeg2;
  logic [2:0]      stuff_left;
  logic [16:0]     limit_bytes;

  frame_res_t  expected_frames[$];
  int          fail_count  = 0;
  int          bytes_sent  = 0;
  int          idle_cycles = 0;
  bit          no_gaps     = 1'b0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 25);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void push_frame(input logic [7:0] data, input logic first,
                                     input logic last, input logic run,
                                     input logic [1:0] status);
    frame_res_t f;
    f.data   = data;
    f.first  = first;
    f.last   = last;
    f.run    = run;
    f.status = status;
    expected_frames.push_back(f);
  endfunction

  // back to scanning; the window starts empty again
  function automatic void restart_scan();
    scan_phase    = psf_pkg::PH_SCAN;
    prefix_window = '0;
    body_left     = '0;
    pack_mpeg2    = 1'b0;
    stuff_left    = '0;
  endfunction

  function automatic void reset_model();
    limit_bytes = psf_pkg::MAX_PACKET_RESET;
    held_id     = '0;
    held_len_hi = '0;
    restart_scan();
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    int unsigned size;
    logic        mpeg2;
    logic        bad_pack;
    logic [2:0]  stuff;
    case (scan_phase)
      psf_pkg::PH_SCAN: begin
        if (prefix_window == psf_pkg::START_PREFIX) begin
          held_id       = b;
          scan_phase    = psf_pkg::PH_FIFTH;
          prefix_window = '0;
        end else begin
          prefix_window = {prefix_window[15:0], b};
        end
      end
      psf_pkg::PH_FIFTH: begin
        held_len_hi = b;
        scan_phase  = psf_pkg::PH_SIXTH;
      end
      psf_pkg::PH_SIXTH: begin
        size     = 0;
        mpeg2    = 1'b0;
        bad_pack = 1'b0;
        if (held_id != psf_pkg::PACK_ID) begin
          size = {held_len_hi, b};
        end else if ((held_len_hi & psf_pkg::MPEG2_MASK) == psf_pkg::MPEG2_CODE) begin
          size  = psf_pkg::MPEG2_PACK_LEN;
          mpeg2 = 1'b1;
        end else if ((held_len_hi & psf_pkg::MPEG1_MASK) == psf_pkg::MPEG1_CODE) begin
          size = psf_pkg::MPEG1_PACK_LEN;
        end else begin
          bad_pack = 1'b1;
        end
        if (bad_pack) begin
          push_frame(8'h00, 1'b0, 1'b0, 1'b1, psf_pkg::STATUS_BAD_PACK);
          restart_scan();
        end else if (size + psf_pkg::HDR_BYTES > limit_bytes) begin
          push_frame(8'h00, 1'b0, 1'b0, 1'b1, psf_pkg::STATUS_TOO_LARGE);
          restart_scan();
        end else begin
          // header burst: start code, stream id, the held fifth byte and this sixth byte
          push_frame(8'h00, 1'b1, 1'b0, 1'b0, psf_pkg::STATUS_OK);
          push_frame(8'h00, 1'b0, 1'b0, 1'b0, psf_pkg::STATUS_OK);
          push_frame(8'h01, 1'b0, 1'b0, 1'b0, psf_pkg::STATUS_OK);
          push_frame(held_id, 1'b0, 1'b0, 1'b0, psf_pkg::STATUS_OK);
          push_frame(held_len_hi, 1'b0, 1'b0, 1'b0, psf_pkg::STATUS_OK);
          push_frame(b, 1'b0, size == 0, 1'b1, psf_pkg::STATUS_OK);
          if (size == 0) begin
            restart_scan();
          end else begin
            body_left  = size[16:0];
            pack_mpeg2 = mpeg2;
            scan_phase = psf_pkg::PH_BODY;
          end
        end
      end
      psf_pkg::PH_BODY: begin
        body_left = body_left - 17'd1;
        push_frame(b, 1'b0, body_left == 0, 1'b1, psf_pkg::STATUS_OK);
        if (body_left == 0) begin
          // MPEG-2 pack: low bits of the last byte count stuffing to drop
          stuff = pack_mpeg2 ? b[2:0] : 3'd0;
          restart_scan();
          if (stuff != 0) begin
            stuff_left = stuff;
            scan_phase = psf_pkg::PH_STUFF;
          end
        end
      end
      psf_pkg::PH_STUFF: begin
        stuff_left = stuff_left - 3'd1;
        if (stuff_left == 0) restart_scan();
      end
      default: restart_scan();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while (take_gap()) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    frame_byte(b);
  endtask

  task automatic send_bytes(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // hold off the sender until every expected result has come out
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_limit_readback();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(limit_bytes)) begin
      $error("max_packet_bytes: expected %0d, actual %0d", limit_bytes, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write only with the block idle
  task automatic set_limit(input logic [31:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_bytes = value[16:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_limit_readback();
  endtask

  // result sink with random stalls
  always @(negedge clk) begin
    out_ch.ready <= !take_gap();
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    frame_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result: out_byte %02h status %0d", out_ch.out_byte,
               out_ch.status);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.first_of_packet !== want.first) begin
          $error("first_of_packet: expected %0b, actual %0b", want.first,
                 out_ch.first_of_packet);
          fail_count++;
        end
        if (out_ch.last_of_packet !== want.last) begin
          $error("last_of_packet: expected %0b, actual %0b", want.last,
                 out_ch.last_of_packet);
          fail_count++;
        end
        if (out_ch.last_of_run !== want.run) begin
          $error("last_of_run: expected %0b, actual %0b", want.run, out_ch.last_of_run);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // overlapped prefix, window cleared after a packet, empty packet
  task automatic test_ordinary_packets();
    send_bytes('{8'h5A, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h02,
                 8'hAA, 8'h00});
    send_bytes('{8'h00, 8'h01, 8'hC0});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBD, 8'h00, 8'h00});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h01, 8'hFF});
  endtask

  // MPEG-2 with and without stuffing, MPEG-1, unknown pack types
  task automatic test_pack_headers();
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'h7F, 8'h01,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB,
                 8'h00, 8'h00, 8'h01, 8'hE0});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'h44, 8'h00,
                 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'hF8});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'h2F, 8'h00,
                 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h07});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'h80, 8'h00});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'hFF, 8'hFF});
  endtask

  // size limit at its extremes, including the largest length field
  task automatic test_size_limit();
    set_limit(32'd6);
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h01});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'h21, 8'h00});
    set_limit(32'd0);
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00});
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hBA, 8'hC0, 8'h00});
    set_limit(32'd131071);
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h03, 8'hAA, 8'h55, 8'h01});
    set_limit(32'd65540);
    send_bytes('{8'h00, 8'h00, 8'h01, 8'hE0, 8'hFF, 8'hFF});
  endtask

  // noise, then mostly well-formed packets with random content
  task automatic send_random_packet();
    logic [7:0] sid;
    logic [7:0] hi;
    logic [7:0] lo;
    repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 10) begin
      // broken start code
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'($urandom_range(255)));
    end else begin
      sid = ($urandom_range(99) < 35) ? psf_pkg::PACK_ID : 8'($urandom_range(255));
      lo  = 8'($urandom_range(255));
      if (sid == psf_pkg::PACK_ID) begin
        case ($urandom_range(2))
          0:       hi = {2'b01, 6'($urandom_range(63))};
          1:       hi = {4'h2, 4'($urandom_range(15))};
          default: hi = 8'($urandom_range(255));
        endcase
      end else if (limit_bytes < 100 && $urandom_range(99) < 30) begin
        hi = 8'($urandom_range(255));
      end else begin
        hi = 8'h00;
        lo = 8'($urandom_range(12));
      end
      send_bytes('{8'h00, 8'h00, 8'h01, sid, hi, lo});
      while (scan_phase == psf_pkg::PH_BODY || scan_phase == psf_pkg::PH_STUFF)
        send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_stream();
    int target;
    logic [31:0] lim;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       lim = 32'($urandom_range(6, 24));
        1:       lim = 32'd131071;
        2:       lim = 32'($urandom_range(6, 40));
        default: lim = 32'($urandom_range(10, 20));
      endcase
      set_limit(lim);
      // one longer phase runs with no stalls on either side
      no_gaps = (ph == 2);
      target  = bytes_sent + ((ph == 2) ? 24 : 8);
      while (bytes_sent < target) send_random_packet();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_limit_readback();

    test_ordinary_packets();
    test_pack_headers();
    test_size_limit();
    test_random_stream();

    drain_results();
    repeat (20) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d expected results never arrived", expected_frames.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
